// ===== src/stt_pkg.sv =====
// Shared types, constants and helper functions of the source text tokenizer.
package stt_pkg;

    // Depth of the bundle queue between the classifier and the output sequencer.
    localparam int QUEUE_DEPTH = 2;

    // One input byte causes at most this many results.
    localparam int MAX_EVENTS = 3;
    localparam int CNT_W      = $clog2(MAX_EVENTS + 1);

    // Scan modes of the classifier.
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_STR,
        MODE_IDENT,
        MODE_OPWAIT
    } stt_mode_t;

    // Token classes.
    typedef enum logic [2:0] {
        CLS_NUM,
        CLS_STR,
        CLS_BOOL,
        CLS_IDENT,
        CLS_PUNC,
        CLS_OP
    } stt_class_t;

    // Event kinds.
    localparam logic EV_CHAR = 1'b0;
    localparam logic EV_END  = 1'b1;

    // Keyword tracker codes: 1..4 walk "true", 5..9 walk "false".
    localparam logic [3:0] KW_EMPTY = 4'd0;
    localparam logic [3:0] KW_TRUE  = 4'd4;
    localparam logic [3:0] KW_FALSE = 4'd9;
    localparam logic [3:0] KW_NONE  = 4'd15;

    // One result item.
    typedef struct packed {
        logic       kind;
        stt_class_t cls;
        logic [7:0] chr;
    } stt_event_t;

    // All results caused by one input byte, in order.
    typedef struct packed {
        logic [CNT_W-1:0]                cnt;
        stt_event_t [MAX_EVENTS-1:0]     ev;
    } stt_bundle_t;

    // Advance the keyword tracker by one identifier character.
    function automatic logic [3:0] kw_advance(input logic [3:0] k, input logic [7:0] c);
        logic [3:0] r;
        r = KW_NONE;
        case (k)
            4'd0:
            begin
                if (c == "t")
                    r = 4'd1;
                else if (c == "f")
                    r = 4'd5;
            end
            4'd1: r = (c == "r") ? 4'd2 : KW_NONE;
            4'd2: r = (c == "u") ? 4'd3 : KW_NONE;
            4'd3: r = (c == "e") ? 4'd4 : KW_NONE;
            4'd5: r = (c == "a") ? 4'd6 : KW_NONE;
            4'd6: r = (c == "l") ? 4'd7 : KW_NONE;
            4'd7: r = (c == "s") ? 4'd8 : KW_NONE;
            4'd8: r = (c == "e") ? 4'd9 : KW_NONE;
            default: r = KW_NONE;
        endcase
        return r;
    endfunction

endpackage

// ===== src/stt_front.sv =====
// Front end: accepts text bytes, tracks the scan state and builds result bundles.
module stt_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          text_byte,
    input  logic                end_of_text,
    input  logic                q_full,
    output logic                push,
    output stt_pkg::stt_bundle_t bundle
);

    stt_pkg::stt_mode_t mode_reg, mode_next, mode_mid;
    logic               quote_reg, quote_next;
    logic [3:0]         kw_reg, kw_next, kw_mid;

    // Results of processing the byte from idle.
    stt_pkg::stt_mode_t  fr_mode;
    logic [3:0]          fr_kw;
    logic                fr_char;
    logic                fr_end;
    logic                fr_quote;
    stt_pkg::stt_class_t fr_cls;

    // Candidate results in output order: close, character, immediate end, final close.
    logic                a_v, b_v, b2_v, c_v;
    stt_pkg::stt_class_t a_cls, b_cls, b2_cls, c_cls;
    logic                use_fresh;
    logic                accept;

    logic is_space, is_digit, is_alpha, is_punct, is_op1, is_op2, is_quote;

    // Class carried by the end marker of the open token.
    function automatic stt_pkg::stt_class_t close_class(input stt_pkg::stt_mode_t m,
                                                        input logic [3:0] k);
        stt_pkg::stt_class_t r;
        r = stt_pkg::CLS_OP;
        case (m)
            stt_pkg::MODE_NUM:   r = stt_pkg::CLS_NUM;
            stt_pkg::MODE_STR:   r = stt_pkg::CLS_STR;
            stt_pkg::MODE_IDENT:
            begin
                r = (k == stt_pkg::KW_TRUE || k == stt_pkg::KW_FALSE)
                    ? stt_pkg::CLS_BOOL : stt_pkg::CLS_IDENT;
            end
            default: r = stt_pkg::CLS_OP;
        endcase
        return r;
    endfunction

    // Byte classes.
    always_comb
    begin
        is_space = (text_byte == " ") || (text_byte >= 8'd9 && text_byte <= 8'd13);
        is_digit = text_byte inside {["0":"9"]};
        is_alpha = text_byte inside {["a":"z"], ["A":"Z"]};
        is_punct = text_byte inside {"(", ")", "{", "}", ";", ","};
        is_op1   = text_byte inside {"+", "-", "*", "/", "%", "|", "&"};
        is_op2   = text_byte inside {"=", "<", ">", "!"};
        is_quote = (text_byte == "'") || (text_byte == "\"");
    end

    // Processing of the byte as if the scanner were idle.
    always_comb
    begin
        fr_mode  = stt_pkg::MODE_IDLE;
        fr_kw    = stt_pkg::KW_EMPTY;
        fr_char  = 1'b0;
        fr_end   = 1'b0;
        fr_quote = 1'b0;
        fr_cls   = stt_pkg::CLS_NUM;
        if (is_space)
        begin
            fr_mode = stt_pkg::MODE_IDLE;
        end
        else if (is_digit)
        begin
            fr_char = 1'b1;
            fr_cls  = stt_pkg::CLS_NUM;
            fr_mode = stt_pkg::MODE_NUM;
        end
        else if (is_quote)
        begin
            fr_quote = 1'b1;
            fr_mode  = stt_pkg::MODE_STR;
        end
        else if (is_alpha || text_byte == "_")
        begin
            fr_char = 1'b1;
            fr_cls  = stt_pkg::CLS_IDENT;
            fr_kw   = stt_pkg::kw_advance(stt_pkg::KW_EMPTY, text_byte);
            fr_mode = stt_pkg::MODE_IDENT;
        end
        else if (is_punct)
        begin
            fr_char = 1'b1;
            fr_end  = 1'b1;
            fr_cls  = stt_pkg::CLS_PUNC;
        end
        else if (is_op1)
        begin
            fr_char = 1'b1;
            fr_end  = 1'b1;
            fr_cls  = stt_pkg::CLS_OP;
        end
        else if (is_op2)
        begin
            fr_char = 1'b1;
            fr_cls  = stt_pkg::CLS_OP;
            fr_mode = stt_pkg::MODE_OPWAIT;
        end
    end

    // Scan state update and candidate results.
    always_comb
    begin
        mode_mid   = mode_reg;
        kw_mid     = kw_reg;
        quote_next = quote_reg;
        a_v        = 1'b0;
        b_v        = 1'b0;
        b_cls      = stt_pkg::CLS_NUM;
        b2_v       = 1'b0;
        b2_cls     = stt_pkg::CLS_OP;
        use_fresh  = 1'b0;
        a_cls      = close_class(mode_reg, kw_reg);

        case (mode_reg)
            stt_pkg::MODE_NUM:
            begin
                if (is_digit)
                begin
                    b_v   = 1'b1;
                    b_cls = stt_pkg::CLS_NUM;
                end
                else
                begin
                    a_v       = 1'b1;
                    use_fresh = 1'b1;
                end
            end
            stt_pkg::MODE_STR:
            begin
                if (text_byte == (quote_reg ? 8'("\"") : 8'("'")))
                begin
                    a_v      = 1'b1;
                    mode_mid = stt_pkg::MODE_IDLE;
                    kw_mid   = stt_pkg::KW_EMPTY;
                end
                else
                begin
                    b_v   = 1'b1;
                    b_cls = stt_pkg::CLS_STR;
                end
            end
            stt_pkg::MODE_IDENT:
            begin
                if (is_alpha || is_digit || text_byte == "_")
                begin
                    b_v    = 1'b1;
                    b_cls  = stt_pkg::CLS_IDENT;
                    kw_mid = stt_pkg::kw_advance(kw_reg, text_byte);
                end
                else
                begin
                    a_v       = 1'b1;
                    use_fresh = 1'b1;
                end
            end
            stt_pkg::MODE_OPWAIT:
            begin
                if (text_byte == "=")
                begin
                    b_v      = 1'b1;
                    b_cls    = stt_pkg::CLS_OP;
                    b2_v     = 1'b1;
                    b2_cls   = stt_pkg::CLS_OP;
                    mode_mid = stt_pkg::MODE_IDLE;
                    kw_mid   = stt_pkg::KW_EMPTY;
                end
                else
                begin
                    a_v       = 1'b1;
                    use_fresh = 1'b1;
                end
            end
            default:
            begin
                use_fresh = 1'b1;
            end
        endcase

        if (use_fresh)
        begin
            mode_mid = fr_mode;
            kw_mid   = fr_kw;
            b_v      = fr_char;
            b_cls    = fr_cls;
            b2_v     = fr_end;
            b2_cls   = fr_cls;
            if (fr_quote)
                quote_next = (text_byte == "\"");
        end

        // The final byte closes whatever token is still open.
        c_v   = end_of_text && (mode_mid != stt_pkg::MODE_IDLE);
        c_cls = close_class(mode_mid, kw_mid);
        if (end_of_text)
        begin
            mode_next = stt_pkg::MODE_IDLE;
            kw_next   = stt_pkg::KW_EMPTY;
        end
        else
        begin
            mode_next = mode_mid;
            kw_next   = kw_mid;
        end
    end

    // Pack the candidate results into consecutive bundle slots.
    always_comb
    begin
        logic [stt_pkg::CNT_W-1:0] n;
        n      = '0;
        bundle = '0;
        if (a_v)
        begin
            bundle.ev[n] = '{kind: stt_pkg::EV_END, cls: a_cls, chr: 8'd0};
            n = n + 1'b1;
        end
        if (b_v)
        begin
            bundle.ev[n] = '{kind: stt_pkg::EV_CHAR, cls: b_cls, chr: text_byte};
            n = n + 1'b1;
        end
        if (b2_v)
        begin
            bundle.ev[n] = '{kind: stt_pkg::EV_END, cls: b2_cls, chr: 8'd0};
            n = n + 1'b1;
        end
        if (c_v)
        begin
            bundle.ev[n] = '{kind: stt_pkg::EV_END, cls: c_cls, chr: 8'd0};
            n = n + 1'b1;
        end
        bundle.cnt = n;
    end

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && (bundle.cnt != '0);

    // Scan state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= stt_pkg::MODE_IDLE;
            quote_reg <= 1'b0;
            kw_reg    <= stt_pkg::KW_EMPTY;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
            kw_reg    <= kw_next;
        end
    end

`ifndef SYNTHESIS
    // The final byte of a text always leaves the scanner idle.
    a_eot_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_text) |=> (mode_reg == stt_pkg::MODE_IDLE))
        else $error("scanner not idle after end of text");
`endif

endmodule

// ===== src/stt_queue.sv =====
// Short bundle queue that decouples the classifier from the output sequencer.
module stt_queue
#(
    parameter int DEPTH = stt_pkg::QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  stt_pkg::stt_bundle_t push_data,
    output logic                 full,
    input  logic                 pop,
    output stt_pkg::stt_bundle_t head,
    output logic                 empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    stt_pkg::stt_bundle_t mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Bundle storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

    a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> !empty)
        else $error("queue empty after a push");
`endif

endmodule

// ===== src/stt_back.sv =====
// Back end: sends the results of each queued bundle one item per cycle while out_ready is high.
module stt_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  stt_pkg::stt_bundle_t head,
    input  logic                 empty,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 event_kind,
    output logic [2:0]           token_class,
    output logic [7:0]           token_char,
    output logic                 last_of_run
);

    logic [stt_pkg::CNT_W-1:0] idx_reg;
    stt_pkg::stt_event_t       cur;
    logic                      fire;

    assign out_valid   = !empty;
    assign cur         = head.ev[idx_reg];
    assign last_of_run = (idx_reg == head.cnt - 1'b1);
    assign event_kind  = cur.kind;
    assign token_class = 3'(cur.cls);
    assign token_char  = cur.chr;
    assign fire        = out_valid && out_ready;
    assign pop         = fire && last_of_run;

    // Position inside the head bundle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (pop)
            idx_reg <= '0;
        else if (fire)
            idx_reg <= idx_reg + 1'b1;
    end

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (idx_reg < head.cnt))
        else $error("result index outside head bundle");

    a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(idx_reg))
        else $error("result index moved while stalled");
`endif

endmodule

// ===== src/source_text_tokenizer_unit.sv =====
// Top level of the source text tokenizer: classifier, bundle queue and output sequencer.
//
// Input channel (in_valid / in_ready): one text byte per item, with end_of_text set on
// the final byte of a text. Output channel (out_valid / out_ready): one token event per
// item, either a token character with its provisional class or an end marker carrying
// the final class; last_of_run marks the final event caused by one input byte.
// A byte causes zero to three events. The classifier handles one byte per cycle while
// the queue is not full, writing its events as one bundle into a queue of QUEUE_DEPTH
// entries; bytes that cause no event (whitespace, unknown bytes, opening quotes) leave
// the queue untouched. The events of a byte are registered in the queue and offered
// to the output from there. Bytes are taken one per cycle while each causes at most
// one event and out_ready stays high; a byte that causes several events holds the single
// output port until all are sent. When the receiver stalls, the queue fills and in_ready
// drops once it is full. Reset empties the queue and puts the scanner in its idle state,
// between tokens, with single quote as the string delimiter.
module source_text_tokenizer_unit
#(
    parameter int QUEUE_DEPTH = stt_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       event_kind,
    output logic [2:0] token_class,
    output logic [7:0] token_char,
    output logic       last_of_run
);

    stt_pkg::stt_bundle_t push_data;
    stt_pkg::stt_bundle_t head;
    logic                 push;
    logic                 pop;
    logic                 q_full;
    logic                 q_empty;

    // Byte classification and scan state.
    stt_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .push        (push),
        .bundle      (push_data)
    );

    // Bundle queue between the two halves.
    stt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty)
    );

    // Output sequencing.
    stt_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (q_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_kind  (event_kind),
        .token_class (token_class),
        .token_char  (token_char),
        .last_of_run (last_of_run)
    );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench of the source text tokenizer, with its own token predictor.
`timescale 1ns / 100ps

module tb_top;

    localparam int HALF_PERIOD  = 10;
    localparam int MAX_GAP      = 18;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;
    localparam int RANDOM_BYTES = 400;
    localparam int HOLD_CYCLES  = 60;

    // First step of each keyword walk.
    localparam logic [3:0] KW_T_FIRST = 4'd1;
    localparam logic [3:0] KW_F_FIRST = 4'd5;

    // One token event as it is expected on the output channel.
    typedef struct packed {
        logic                kind;
        stt_pkg::stt_class_t cls;
        logic [7:0]          chr;
        logic                last;
    } tok_event_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] text_byte;
    logic       end_of_text;
    logic       out_valid;
    logic       out_ready;
    logic       event_kind;
    logic [2:0] token_class;
    logic [7:0] token_char;
    logic       last_of_run;

    // Predicted scanner state.
    stt_pkg::stt_mode_t scan_st;
    logic               dq_close;
    logic [3:0]         kw_state;

    tok_event_t expected_events[$];
    tok_event_t byte_events[$];

    int  mismatches;
    int  bytes_sent;
    int  rx_hold_cycles;
    bit  tx_idle_on;
    bit  rx_idle_on;
    bit  random_eot;

    source_text_tokenizer_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_kind  (event_kind),
        .token_class (token_class),
        .token_char  (token_char),
        .last_of_run (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    // Character classes outside of strings.
    function automatic bit is_ws(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic bit is_sep(logic [7:0] c);
        return c inside {"(", ")", "{", "}", ";", ","};
    endfunction

    function automatic bit is_single_op(logic [7:0] c);
        return c inside {"+", "-", "*", "/", "%", "|", "&"};
    endfunction

    function automatic bit is_pair_op(logic [7:0] c);
        return c inside {"=", "<", ">", "!"};
    endfunction

    // Walk the identifier against the two boolean keywords.
    function automatic logic [3:0] kw_next(logic [3:0] k, logic [7:0] c);
        string tw;
        string fw;
        tw = "true";
        fw = "false";
        if (k == stt_pkg::KW_EMPTY)
        begin
            if (c == "t")
                return KW_T_FIRST;
            if (c == "f")
                return KW_F_FIRST;
            return stt_pkg::KW_NONE;
        end
        if (k >= KW_T_FIRST && k < stt_pkg::KW_TRUE)
            return (c == tw[k]) ? k + 4'd1 : stt_pkg::KW_NONE;
        if (k >= KW_F_FIRST && k < stt_pkg::KW_FALSE)
            return (c == fw[k - 4'd4]) ? k + 4'd1 : stt_pkg::KW_NONE;
        return stt_pkg::KW_NONE;
    endfunction

    task automatic add_event(logic kind, stt_pkg::stt_class_t cls, logic [7:0] chr);
        tok_event_t e;
        e.kind = kind;
        e.cls  = cls;
        e.chr  = (kind == stt_pkg::EV_END) ? 8'h00 : chr;
        e.last = 1'b0;
        byte_events.push_back(e);
    endtask

    // Emit the end marker of the open token, if any, and go idle.
    task automatic close_open_token();
        case (scan_st)
            stt_pkg::MODE_NUM:    add_event(stt_pkg::EV_END, stt_pkg::CLS_NUM, 8'h00);
            stt_pkg::MODE_STR:    add_event(stt_pkg::EV_END, stt_pkg::CLS_STR, 8'h00);
            stt_pkg::MODE_OPWAIT: add_event(stt_pkg::EV_END, stt_pkg::CLS_OP, 8'h00);
            stt_pkg::MODE_IDENT:
            begin
                if (kw_state == stt_pkg::KW_TRUE || kw_state == stt_pkg::KW_FALSE)
                    add_event(stt_pkg::EV_END, stt_pkg::CLS_BOOL, 8'h00);
                else
                    add_event(stt_pkg::EV_END, stt_pkg::CLS_IDENT, 8'h00);
            end
            default:
            begin
            end
        endcase
        scan_st  = stt_pkg::MODE_IDLE;
        kw_state = stt_pkg::KW_EMPTY;
    endtask

    // Handle a byte seen between tokens.
    task automatic begin_token(logic [7:0] c);
        scan_st  = stt_pkg::MODE_IDLE;
        kw_state = stt_pkg::KW_EMPTY;
        if (is_ws(c))
            return;
        if (is_num(c))
        begin
            add_event(stt_pkg::EV_CHAR, stt_pkg::CLS_NUM, c);
            scan_st = stt_pkg::MODE_NUM;
        end
        else if (c == "'" || c == "\"")
        begin
            dq_close = (c == "\"");
            scan_st  = stt_pkg::MODE_STR;
        end
        else if (is_letter(c) || c == "_")
        begin
            add_event(stt_pkg::EV_CHAR, stt_pkg::CLS_IDENT, c);
            kw_state = kw_next(stt_pkg::KW_EMPTY, c);
            scan_st  = stt_pkg::MODE_IDENT;
        end
        else if (is_sep(c))
        begin
            add_event(stt_pkg::EV_CHAR, stt_pkg::CLS_PUNC, c);
            add_event(stt_pkg::EV_END, stt_pkg::CLS_PUNC, 8'h00);
        end
        else if (is_single_op(c))
        begin
            add_event(stt_pkg::EV_CHAR, stt_pkg::CLS_OP, c);
            add_event(stt_pkg::EV_END, stt_pkg::CLS_OP, 8'h00);
        end
        else if (is_pair_op(c))
        begin
            add_event(stt_pkg::EV_CHAR, stt_pkg::CLS_OP, c);
            scan_st = stt_pkg::MODE_OPWAIT;
        end
    endtask

    // Work out the events of one accepted byte and queue them.
    task automatic predict_byte(logic [7:0] c, logic eot);
        tok_event_t e;
        byte_events.delete();
        case (scan_st)
            stt_pkg::MODE_NUM:
            begin
                if (is_num(c))
                    add_event(stt_pkg::EV_CHAR, stt_pkg::CLS_NUM, c);
                else
                begin
                    close_open_token();
                    begin_token(c);
                end
            end
            stt_pkg::MODE_STR:
            begin
                if (c == (dq_close ? 8'h22 : 8'h27))
                    close_open_token();
                else
                    add_event(stt_pkg::EV_CHAR, stt_pkg::CLS_STR, c);
            end
            stt_pkg::MODE_IDENT:
            begin
                if (is_letter(c) || is_num(c) || c == "_")
                begin
                    add_event(stt_pkg::EV_CHAR, stt_pkg::CLS_IDENT, c);
                    kw_state = kw_next(kw_state, c);
                end
                else
                begin
                    close_open_token();
                    begin_token(c);
                end
            end
            stt_pkg::MODE_OPWAIT:
            begin
                if (c == "=")
                begin
                    add_event(stt_pkg::EV_CHAR, stt_pkg::CLS_OP, c);
                    close_open_token();
                end
                else
                begin
                    close_open_token();
                    begin_token(c);
                end
            end
            default: begin_token(c);
        endcase
        if (eot)
            close_open_token();
        for (int i = 0; i < byte_events.size(); i++)
        begin
            e = byte_events[i];
            e.last = (i == byte_events.size() - 1);
            expected_events.push_back(e);
        end
    endtask

    // Offer one byte after a random gap and predict its events once accepted.
    task automatic send_byte(logic [7:0] b, logic eot);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        text_byte   <= b;
        end_of_text <= eot;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_byte(b, eot);
        bytes_sent++;
    endtask

    task automatic send_text(string s, bit eot_at_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eot_at_end && (i == s.len() - 1));
    endtask

    // Byte of the random part, now and then flagged as the end of the text.
    task automatic put(logic [7:0] b);
        send_byte(b, random_eot && ($urandom_range(0, 39) == 0));
    endtask

    // Stop offering and let every expected event come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] word_char(bit lead);
        int r;
        r = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
        if (r < 26)
            return 8'(r) + "a";
        if (r < 52)
            return 8'(r - 26) + "A";
        if (r == 52 || r == 62)
            return "_";
        return 8'(r - 53) + "0";
    endfunction

    // Edge cases: keywords, every quote form, pending operators, unknown bytes.
    task automatic test_directed();
        send_text("true ", 0);
        send_text("false", 1);
        send_text("x1_(", 0);
        send_text("7a", 0);
        send_text("<=", 0);
        send_byte("!", 0);
        send_byte(8'h00, 0);
        send_text("'\"", 0);
        send_byte(8'h00, 1);
        send_text("\"\"", 0);
        send_text("9", 1);
        send_byte(8'hFF, 0);
        send_byte(8'h09, 0);
        send_text(">", 1);
        wait_drained();
    endtask

    // Well-formed token streams with random content, plus noise bytes.
    task automatic test_random_text();
        int start;
        int pick;
        int n;
        int extra;
        string kw;
        logic [7:0] q;
        logic [7:0] c;
        start = bytes_sent;
        random_eot = 1'b1;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            // Change the idling pattern every few dozen bytes.
            if ($urandom_range(0, 29) == 0)
            begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 15);
            case (pick)
                0, 1:
                begin
                    n = $urandom_range(1, 4);
                    repeat (n) put(8'($urandom_range(0, 9)) + "0");
                end
                2, 3:
                begin
                    put(word_char(1));
                    n = $urandom_range(0, 5);
                    repeat (n) put(word_char(0));
                end
                4:
                begin
                    if ($urandom_range(0, 1))
                        kw = "true";
                    else
                        kw = "false";
                    n = $urandom_range(0, 1) ? kw.len() : $urandom_range(1, kw.len());
                    extra = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
                    for (int i = 0; i < n; i++)
                        put(kw[i]);
                    repeat (extra) put(word_char(0));
                end
                5, 6:
                begin
                    q = $urandom_range(0, 1) ? 8'h22 : 8'h27;
                    put(q);
                    n = $urandom_range(0, 5);
                    repeat (n)
                    begin
                        c = 8'($urandom_range(0, 255));
                        if (c == q)
                            c = 8'h00;
                        put(c);
                    end
                    if ($urandom_range(0, 4) != 0)
                        put(q);
                end
                7, 8:
                begin
                    kw = "(){};,";
                    put(kw[$urandom_range(0, 5)]);
                end
                9, 10:
                begin
                    kw = "+-*/%|&";
                    put(kw[$urandom_range(0, 6)]);
                end
                11, 12:
                begin
                    kw = "=<>!";
                    put(kw[$urandom_range(0, 3)]);
                    if ($urandom_range(0, 1))
                        put("=");
                end
                13, 14:
                begin
                    put($urandom_range(0, 5) == 0 ? 8'h20 : 8'($urandom_range(9, 13)));
                end
                default: put(8'($urandom_range(0, 255)));
            endcase
        end
        random_eot = 1'b0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        wait_drained();
    endtask

    // Long receiver hold-off while multi-event bytes keep coming: the input must stall.
    task automatic test_output_stall();
        tx_idle_on = 1'b0;
        rx_hold_cycles = HOLD_CYCLES;
        send_text("(){};,+-*/%|&<=!x", 1);
        tx_idle_on = 1'b1;
        wait_drained();
    endtask

    // Sender pauses with a token open until the output has fully drained.
    task automatic test_pause_mid_token();
        send_text("abc+(12", 0);
        wait_drained();
        send_text("==", 0);
        wait_drained();
        send_text("'x y", 1);
        wait_drained();
    endtask

    // Receiver: random stalls, a requested long hold-off, and a check of every event.
    initial
    begin
        int stall_left;
        tok_event_t e;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected event: kind %0d class %0d char %02h last %0d",
                                 event_kind, token_class, token_char, last_of_run);
                end
                else
                begin
                    e = expected_events.pop_front();
                    if (event_kind !== e.kind || token_class !== e.cls ||
                        token_char !== e.chr || last_of_run !== e.last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"event mismatch: kind %0d/%0d class %0d/%0d ",
                                      "char %02h/%02h last %0d/%0d (expected/actual)"},
                                     e.kind, event_kind, e.cls, token_class,
                                     e.chr, token_char, e.last, last_of_run);
                    end
                end
                stall_left = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (rx_hold_cycles > 0)
            begin
                rx_hold_cycles--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Main sequence.
    initial
    begin
        in_valid    <= 1'b0;
        text_byte   <= 8'h00;
        end_of_text <= 1'b0;
        rst_n       <= 1'b0;
        scan_st        = stt_pkg::MODE_IDLE;
        dq_close       = 1'b0;
        kw_state       = stt_pkg::KW_EMPTY;
        mismatches     = 0;
        bytes_sent     = 0;
        rx_hold_cycles = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        random_eot     = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_output_stall();
        test_pause_mid_token();
        test_random_text();

        mismatches += expected_events.size();
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #(10_000_000);
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
src/stt_pkg.sv
src/stt_front.sv
src/stt_queue.sv
src/stt_back.sv
src/source_text_tokenizer_unit.sv
dv/tb_top.sv
